### rtl/core/crd_pkg.sv
package crd_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CNT_W = 5;
   localparam int unsigned REQ_DATA_W = 144;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [DATA_W-1:0] TOP_BOUND = 32'd16777216;
   localparam logic [DATA_W-1:0] BOTTOM_BOUND = 32'd32768;
   localparam logic [DATA_W-1:0] RANGE_INIT = 32'hFFFF_FFFF;
   localparam logic [2:0] PRIME_BYTES = 3'd4;

   typedef enum logic [2:0] {
      KIND_START  = 3'd0,
      KIND_BYTE   = 3'd1,
      KIND_THRESH = 3'd2,
      KIND_DECODE = 3'd3,
      KIND_BIT    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DIV0  = 2'd1,
      STATUS_OWED  = 2'd2
   } status_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/core/crd_div.sv
module crd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  crd_pkg::div_req_type div_req,
   output crd_pkg::div_rsp_type div_rsp
);
   import crd_pkg::*;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;
   logic              ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DATA_W-1]};
      diff = rem_sh - {1'b0, dvs_ff};
      ge = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ge};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### rtl/core/carryless_range_decoder_core.sv
// Channel  Dir  Fields (tdata low bit up / tuser)
// req      in   tdata: byte_value, total, start_req, size, bit_size0, total_bits; tuser: kind
// rsp      out  tdata: value, byte_wanted; tuser: status
//
// Start, unused kinds, an unwanted byte and flagged commands go straight from IDLE to DONE.
// Normalizing byte: NORM, then DONE. Decode: MUL1 and MUL2 (shared multiplier twice), then the NORM test.
// Threshold: DIV1 then DIV2 (only DIV1 when the scaled range is zero); decode bit: DIV2, MUL1, MUL2
// and NORM; each division runs on the 32-step radix-2 divider.
// reset clears range, low, code, the priming counter and the pending-byte flag to zero.
// req_tready is low while a word is in work; a stalled rsp holds the next word back.
module carryless_range_decoder_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // byte_value, total, start_req, size, bit_size0, total_bits
   input  logic [2:0]   req_tuser,  // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // value, byte_wanted
   output logic [1:0]   rsp_tuser   // status
);
   import crd_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV1 = 7'b0000010,
      ST_DIV2 = 7'b0000100,
      ST_MUL1 = 7'b0001000,
      ST_MUL2 = 7'b0010000,
      ST_NORM = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] range_ff, range_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] code_ff, code_in;
   logic [2:0]        prime_ff, prime_in;
   logic              pend_ff, pend_in;
   kind_type          kind_ff, kind_in;
   logic [DATA_W-1:0] opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic [DATA_W-1:0] size0_ff, size0_in;
   logic [4:0]        tbits_ff, tbits_in;
   logic [DATA_W-1:0] val_ff, val_in;
   status_type        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_want_ff, rsp_want_in;
   status_type        rsp_st_ff, rsp_st_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [7:0]        f_byte;
   logic [DATA_W-1:0] f_total, f_start, f_size, f_size0;
   logic [4:0]        f_tbits;
   logic              owed;
   logic              accept;
   logic [DATA_W-1:0] shifted;
   logic [DATA_W-1:0] mul_p;
   logic [DATA_W-1:0] low_sum;
   logic [DATA_W-1:0] diff_cl;

   assign f_byte  = req_tdata[7:0];
   assign f_total = req_tdata[39:8];
   assign f_start = req_tdata[71:40];
   assign f_size  = req_tdata[103:72];
   assign f_size0 = req_tdata[135:104];
   assign f_tbits = req_tdata[140:136];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign owed = (prime_ff != 3'd0) || pend_ff;
   assign shifted = range_ff >> f_tbits;
   assign mul_p = opa_ff * range_ff;
   assign low_sum = low_ff + range_ff;
   assign diff_cl = code_ff - low_ff;

   crd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      range_in = range_ff;
      low_in = low_ff;
      code_in = code_ff;
      prime_in = prime_ff;
      pend_in = pend_ff;
      kind_in = kind_ff;
      opa_in = opa_ff;
      opb_in = opb_ff;
      size0_in = size0_ff;
      tbits_in = tbits_ff;
      val_in = val_ff;
      st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_want_in = rsp_want_ff;
      rsp_st_in = rsp_st_ff;
      div_req.start = 1'b0;
      div_req.dividend = diff_cl;
      div_req.divisor = range_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind_type'(req_tuser);
               val_in = '0;
               st_in = STATUS_OK;
               size0_in = f_size0;
               tbits_in = f_tbits;
               opa_in = f_start;
               opb_in = f_size;
               state_in = ST_DONE;
               unique case (req_tuser)
                  KIND_START: begin
                     code_in = '0;
                     low_in = '0;
                     range_in = RANGE_INIT;
                     prime_in = PRIME_BYTES;
                     pend_in = 1'b0;
                  end
                  KIND_BYTE: begin
                     if (prime_ff != 3'd0) begin
                        code_in = {code_ff[DATA_W-9:0], f_byte};
                        prime_in = prime_ff - 3'd1;
                     end else if (pend_ff) begin
                        code_in = {code_ff[DATA_W-9:0], f_byte};
                        range_in = {range_ff[DATA_W-9:0], 8'd0};
                        low_in = {low_ff[DATA_W-9:0], 8'd0};
                        state_in = ST_NORM;
                     end
                  end
                  KIND_THRESH: begin
                     if (owed) begin
                        st_in = STATUS_OWED;
                     end else if (f_total == '0) begin
                        st_in = STATUS_DIV0;
                     end else begin
                        div_req.start = 1'b1;
                        div_req.dividend = range_ff;
                        div_req.divisor = f_total;
                        state_in = ST_DIV1;
                     end
                  end
                  KIND_DECODE: begin
                     if (owed) begin
                        st_in = STATUS_OWED;
                     end else begin
                        state_in = ST_MUL1;
                     end
                  end
                  KIND_BIT: begin
                     if (owed) begin
                        st_in = STATUS_OWED;
                     end else if (shifted == '0) begin
                        st_in = STATUS_DIV0;
                     end else begin
                        range_in = shifted;
                        div_req.start = 1'b1;
                        div_req.divisor = shifted;
                        state_in = ST_DIV2;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  st_in = STATUS_DIV0;
                  state_in = ST_DONE;
               end else begin
                  range_in = div_rsp.quotient;
                  div_req.start = 1'b1;
                  div_req.divisor = div_rsp.quotient;
                  state_in = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               if (kind_ff == KIND_THRESH) begin
                  val_in = div_rsp.quotient;
                  state_in = ST_DONE;
               end else begin
                  if (div_rsp.quotient < size0_ff) begin
                     opa_in = '0;
                     opb_in = size0_ff;
                     val_in = '0;
                  end else begin
                     opa_in = size0_ff;
                     opb_in = (DATA_W'(1) << tbits_ff) - size0_ff;
                     val_in = DATA_W'(1);
                  end
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            low_in = low_ff + mul_p;
            opa_in = opb_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            range_in = mul_p;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if ((low_ff ^ low_sum) < TOP_BOUND) begin
               pend_in = 1'b1;
            end else if (range_ff < BOTTOM_BOUND) begin
               range_in = (DATA_W'(0) - low_ff) & (BOTTOM_BOUND - DATA_W'(1));
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = val_ff;
               rsp_want_in = owed;
               rsp_st_in = st_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         range_ff <= '0;
         low_ff <= '0;
         code_ff <= '0;
         prime_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         range_ff <= range_in;
         low_ff <= low_in;
         code_ff <= code_in;
         prime_ff <= prime_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      size0_ff <= size0_in;
      tbits_ff <= tbits_in;
      val_ff <= val_in;
      st_ff <= st_in;
      rsp_value_ff <= rsp_value_in;
      rsp_want_ff <= rsp_want_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_want_ff, rsp_value_ff};
   assign rsp_tuser = rsp_st_ff;

endmodule

### tb/sv/crd_checker.sv
`timescale 1ns / 1ps

module crd_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,  // byte_value, total, start_req, size, bit_size0, total_bits
   input  logic [2:0]   req_tuser,  // kind
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,  // value, byte_wanted
   input  logic [1:0]   rsp_tuser,  // status
   output int unsigned  fail_count,
   output int unsigned  pending,
   output logic         bytes_owed,
   output logic [31:0]  last_value,
   output int unsigned  words_checked,
   output int unsigned  div0_count,
   output int unsigned  owed_count
);
   import crd_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic        wanted;
      status_type  status;
   } decoded_type;

   decoded_type decoded_q[$];
   logic [31:0] range_q;
   logic [31:0] low_q;
   logic [31:0] code_q;
   logic [2:0]  prime_q;
   logic        norm_q;

   assign bytes_owed = (prime_q != 3'd0) || norm_q;

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want_v);
      $display("%0t rsp %s: got %h expected %h", $time, what, got, want_v);
      fail_count++;
   endtask

   // byte owed while low and low+range agree at and above the top bound, or range is too small
   task renorm();
      if ((low_q ^ (low_q + range_q)) < TOP_BOUND) begin
         norm_q = 1'b1;
      end else if (range_q < BOTTOM_BOUND) begin
         range_q = (32'd0 - low_q) & (BOTTOM_BOUND - 32'd1);
         norm_q = 1'b1;
      end else begin
         norm_q = 1'b0;
      end
   endtask

   task narrow(input logic [31:0] step, input logic [31:0] scale);
      low_q = low_q + step * range_q;
      range_q = range_q * scale;
      renorm();
   endtask

   task decode_word(input logic [2:0] kind, input logic [143:0] data, output decoded_type res);
      logic [31:0] total;
      logic [31:0] start_req;
      logic [31:0] size;
      logic [31:0] size0;
      logic [31:0] q;
      logic [4:0]  tbits;
      logic        owed;
      total = data[39:8];
      start_req = data[71:40];
      size = data[103:72];
      size0 = data[135:104];
      tbits = data[140:136];
      owed = (prime_q != 3'd0) || norm_q;
      res.value = 32'd0;
      res.status = STATUS_OK;
      case (kind)
         KIND_START: begin
            code_q = 32'd0;
            low_q = 32'd0;
            range_q = RANGE_INIT;
            prime_q = PRIME_BYTES;
            norm_q = 1'b0;
         end
         KIND_BYTE: begin
            if (prime_q != 3'd0) begin
               code_q = {code_q[23:0], data[7:0]};
               prime_q = prime_q - 3'd1;
            end else if (norm_q) begin
               code_q = {code_q[23:0], data[7:0]};
               range_q = range_q << 8;
               low_q = low_q << 8;
               renorm();
            end
         end
         KIND_THRESH, KIND_DECODE, KIND_BIT: begin
            if (owed) begin
               res.status = STATUS_OWED;
            end else if (kind == KIND_THRESH) begin
               q = 32'd0;
               if (total != 32'd0)
                  q = range_q / total;
               if (q == 32'd0) begin
                  res.status = STATUS_DIV0;
               end else begin
                  range_q = q;
                  res.value = (code_q - low_q) / q;
               end
            end else if (kind == KIND_DECODE) begin
               narrow(start_req, size);
            end else begin
               q = range_q >> tbits;
               if (q == 32'd0) begin
                  res.status = STATUS_DIV0;
               end else begin
                  range_q = q;
                  if (((code_q - low_q) / q) < size0) begin
                     narrow(32'd0, size0);
                  end else begin
                     narrow(size0, (32'd1 << tbits) - size0);
                     res.value = 32'd1;
                  end
               end
            end
         end
         default: ;
      endcase
      res.wanted = (prime_q != 3'd0) || norm_q;
      if (res.status == STATUS_DIV0)
         div0_count++;
      if (res.status == STATUS_OWED)
         owed_count++;
   endtask

   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         decoded_q.delete();
         range_q = 32'd0;
         low_q = 32'd0;
         code_q = 32'd0;
         prime_q = 3'd0;
         norm_q = 1'b0;
         last_value = 32'd0;
         fail_count = 0;
         pending = 0;
         words_checked = 0;
         div0_count = 0;
         owed_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
            end else begin
               want = decoded_q.pop_front();
               words_checked++;
               if (rsp_tdata[31:0] !== want.value)
                  report_mismatch("value", rsp_tdata[31:0], want.value);
               if (rsp_tdata[32] !== want.wanted)
                  report_mismatch("byte_wanted", {31'd0, rsp_tdata[32]}, {31'd0, want.wanted});
               if (rsp_tuser !== want.status)
                  report_mismatch("status", {30'd0, rsp_tuser}, {30'd0, want.status});
            end
         end
         if (req_tvalid && req_tready) begin
            decode_word(req_tuser, req_tdata, want);
            decoded_q.push_back(want);
            last_value = want.value;
         end
         pending = decoded_q.size();
      end
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crd_pkg::*;

   localparam int unsigned ITEM_GOAL = 1600;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned BYTE_TRIES = 6;

   typedef struct packed {
      logic [4:0]  total_bits;
      logic [31:0] bit_size0;
      logic [31:0] size;
      logic [31:0] start_req;
      logic [31:0] total;
      logic [7:0]  byte_value;
   } req_fields_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   int unsigned  fail_count;
   int unsigned  pending;
   logic         bytes_owed;
   logic [31:0]  last_value;
   int unsigned  words_checked;
   int unsigned  div0_count;
   int unsigned  owed_count;

   int unsigned  items_sent = 0;
   int unsigned  frames_run = 0;
   int unsigned  idle_cycles = 0;
   bit           calm = 1'b0;

   carryless_range_decoder_core dut (.*);
   crd_checker u_check (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic req_fields_type random_fields();
      req_fields_type f;
      f.byte_value = 8'($urandom);
      f.total = $urandom;
      f.start_req = $urandom;
      f.size = $urandom;
      f.bit_size0 = $urandom;
      f.total_bits = 5'($urandom_range(0, 31));
      return f;
   endfunction

   task automatic send_word(input logic [2:0] kind, input req_fields_type f);
      int unsigned n;
      n = gap_len();
      items_sent++;
      if (n > 0) begin
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tuser = kind;
      req_tdata = {3'b000, f};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [2:0] kind, input logic [31:0] x, input logic [31:0] y);
      req_fields_type f;
      f = random_fields();
      case (kind)
         KIND_BYTE: f.byte_value = x[7:0];
         KIND_THRESH: f.total = x;
         KIND_DECODE: begin
            f.start_req = x;
            f.size = y;
         end
         KIND_BIT: begin
            f.bit_size0 = x;
            f.total_bits = y[4:0];
         end
         default: ;
      endcase
      send_word(kind, f);
   endtask

   task automatic pay_bytes();
      int unsigned tries;
      tries = 0;
      while (bytes_owed && tries < BYTE_TRIES) begin
         send_op(KIND_BYTE, $urandom, 32'd0);
         tries++;
      end
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // threshold then a consistent decode, or a binary decode
   task automatic run_symbol();
      int unsigned tot;
      int unsigned lo;
      int unsigned hi;
      int unsigned tb;
      if ($urandom_range(0, 99) < 55) begin
         case ($urandom_range(0, 3))
            0: tot = $urandom_range(2, 256);
            1: tot = $urandom_range(2, 4096);
            2: tot = $urandom_range(2, 65535);
            default: tot = 1 << $urandom_range(1, 16);
         endcase
         send_op(KIND_THRESH, tot, 32'd0);
         if (last_value >= tot) begin
            lo = tot - 1;
            hi = tot;
         end else begin
            lo = $urandom_range(0, last_value);
            hi = $urandom_range(last_value + 1, tot);
         end
         send_op(KIND_DECODE, lo, hi - lo);
      end else begin
         tb = $urandom_range(1, 16);
         send_op(KIND_BIT, $urandom_range(1, (1 << tb) - 1), tb);
      end
   endtask

   task automatic run_frame();
      int unsigned symbols;
      symbols = $urandom_range(1, 24);
      send_op(KIND_START, 32'd0, 32'd0);
      pay_bytes();
      repeat (symbols) begin
         if ($urandom_range(0, 19) == 0)
            send_op(3'($urandom_range(KIND_THRESH, KIND_BIT)), $urandom, $urandom);
         else
            run_symbol();
         // now and then leave bytes unpaid so the next command hits the owed check
         if ($urandom_range(0, 19) != 0)
            pay_bytes();
      end
      frames_run++;
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 8)) send_word(3'($urandom_range(0, 7)), random_fields());
   endtask

   initial begin
      int unsigned n;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_START;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_op(KIND_THRESH, 32'd5, 32'd0);    // zero range out of reset
      send_op(KIND_BYTE, 32'hFF, 32'd0);     // nothing owed
      for (int k = int'(KIND_BIT) + 1; k < 8; k++)
         send_word(3'(k), random_fields());
      send_op(KIND_START, 32'd0, 32'd0);
      send_op(KIND_THRESH, 32'd7, 32'd0);
      send_op(KIND_DECODE, 32'd1, 32'd2);
      send_op(KIND_BIT, 32'd1, 32'd1);
      send_op(KIND_START, 32'd0, 32'd0);     // restart while priming
      send_op(KIND_BYTE, 32'h00, 32'd0);
      send_op(KIND_BYTE, 32'hFF, 32'd0);
      send_op(KIND_BYTE, 32'hA5, 32'd0);
      send_op(KIND_BYTE, 32'h5A, 32'd0);
      send_op(KIND_THRESH, 32'd0, 32'd0);
      send_op(KIND_THRESH, 32'hFFFF_FFFF, 32'd0);
      send_op(KIND_BIT, 32'd1, 32'd31);
      send_op(KIND_DECODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      pay_bytes();
      send_op(KIND_START, 32'd0, 32'd0);
      pay_bytes();
      send_op(KIND_BIT, 32'd0, 32'd0);
      send_op(KIND_BIT, 32'hFFFF_FFFF, 32'd1);
      pay_bytes();
      send_op(KIND_DECODE, 32'd0, 32'd0);    // range collapses to zero
      send_op(KIND_BYTE, 32'h3C, 32'd0);
      send_op(KIND_THRESH, 32'd3, 32'd0);
      drain();

      while (items_sent < ITEM_GOAL) begin
         calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) < 7)
            run_frame();
         else
            run_noise();
         if ($urandom_range(0, 15) == 0)
            drain();
      end
      calm = 1'b0;
      drain();
      repeat (100) @(negedge clock);

      $display("drove %0d items in %0d decoder frames plus noise; checked %0d result words",
               items_sent, frames_run, words_checked);
      $display("flagged words seen: %0d divide-by-zero, %0d command while bytes owed",
               div0_count, owed_count);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### carryless_range_decoder_core.f
rtl/core/crd_pkg.sv
rtl/core/crd_div.sv
rtl/core/carryless_range_decoder_core.sv
tb/sv/crd_checker.sv
tb/sv/tb_top.sv
